[src/omds_pkg.sv]
package omds_pkg;

  localparam int MaxWordsDefault = 64;
  localparam int MaxLenDefault   = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] letter;
    logic       last;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } rsp_t;

endpackage

[src/omds_ram.sv]
module omds_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/one_mismatch_dictionary_search_top.sv]
// Load requests: the last letter's result is registered the next cycle.
// Clear gives no result. Search last letter: a sweep of the first len letters
// of every stored word, one stored letter per cycle from the letter memory.
// Reset (rst, synchronous) empties the dictionary and abandons the word in
// progress; memory contents are undefined until written.
module one_mismatch_dictionary_search_top #(
  parameter int MAX_WORDS = omds_pkg::MaxWordsDefault,
  parameter int MAX_LEN   = omds_pkg::MaxLenDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  omds_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output omds_pkg::rsp_t out_data
);
  import omds_pkg::*;

  localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int PW = 6;
  localparam int DW = WW + LW;
  localparam int Depth = 2 ** DW;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  state_t state;
  logic [CW-1:0] word_count;
  logic [PW-1:0] letter_position;
  logic too_long_flag, word_kind;
  logic [WW-1:0] scan_word;
  logic [LW-1:0] scan_pos;
  logic [PW-1:0] qlen;
  logic rd_vld, rd_first, rd_lastpos;
  logic [1:0] diffs;
  logic hit;

  logic accept;
  logic [1:0] op;
  logic is_search, abandon, long_now, store;
  logic scan_go, rsp_now;
  logic [PW-1:0] pos_eff;
  logic [4:0] ltr_q, qry_q;
  logic [5:0] len_q;

  logic lt_we, q_we, len_we;
  logic [DW-1:0] lt_waddr, lt_raddr;
  logic [LW-1:0] q_addr_r;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign op = in_data.op;
  assign is_search = (op == OP_SEARCH);
  assign abandon = ((letter_position != '0) || too_long_flag) && (word_kind != is_search);
  assign pos_eff = abandon ? '0 : letter_position;
  assign long_now = (abandon ? 1'b0 : too_long_flag) || (pos_eff >= PW'(MAX_LEN));
  assign store = accept && (op == OP_LOAD || op == OP_SEARCH) && (pos_eff < PW'(MAX_LEN));
  assign lt_we = store && !is_search && (word_count < CW'(MAX_WORDS));
  assign q_we = store && is_search;
  assign lt_waddr = {WW'(word_count), LW'(pos_eff)};
  assign lt_raddr = {scan_word, scan_pos};
  assign q_addr_r = q_we ? LW'(pos_eff) : scan_pos;
  assign len_we = accept && op == OP_LOAD && in_data.last && !long_now
                  && (word_count < CW'(MAX_WORDS));
  assign scan_go = accept && in_data.last && is_search && !long_now && (word_count != '0);
  assign rsp_now = (accept && in_data.last && (op == OP_LOAD || is_search) && !scan_go)
                   || (state == S_WAIT && !rd_vld);

  omds_ram #(.Width(5), .Depth(Depth)) u_letters (
    .clk, .we(lt_we), .waddr(lt_waddr), .wdata(in_data.letter),
    .raddr(lt_raddr), .rdata(ltr_q));
  omds_ram #(.Width(5), .Depth(2 ** LW)) u_query (
    .clk, .we(q_we), .waddr(q_addr_r), .wdata(in_data.letter),
    .raddr(q_addr_r), .rdata(qry_q));
  omds_ram #(.Width(6), .Depth(2 ** WW)) u_lengths (
    .clk, .we(len_we), .waddr(WW'(word_count)), .wdata(pos_eff + 1'b1),
    .raddr(scan_word), .rdata(len_q));

  logic pos_last;
  logic word_last;
  assign pos_last = (PW'(scan_pos) == qlen - PW'(1));
  assign word_last = (CW'(scan_word) == word_count - CW'(1));

  logic [1:0] diffs_n;
  always_comb begin
    diffs_n = rd_first ? 2'd0 : diffs;
    if (rd_vld && (ltr_q != qry_q) && diffs_n != 2'd2) begin
      diffs_n = diffs_n + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      word_count <= '0;
      letter_position <= '0;
      too_long_flag <= 1'b0;
      word_kind <= 1'b0;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      hit <= 1'b0;
    end else begin
      out_valid <= rsp_now || (out_valid && out_stall);
      rd_vld <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_CLEAR) begin
              word_count <= '0;
              letter_position <= '0;
              too_long_flag <= 1'b0;
            end else if (op == OP_LOAD || op == OP_SEARCH) begin
              word_kind <= is_search;
              if (in_data.last) begin
                letter_position <= '0;
                too_long_flag <= 1'b0;
                out_data.found <= 1'b0;
                if (long_now) begin
                  out_data.status <= ST_LONG;
                end else if (is_search) begin
                  out_data.status <= ST_OK;
                  qlen <= pos_eff + 1'b1;
                  hit <= 1'b0;
                  scan_word <= '0;
                  scan_pos <= '0;
                  if (word_count != '0) begin
                    state <= S_SCAN;
                  end
                end else if (word_count >= CW'(MAX_WORDS)) begin
                  out_data.status <= ST_FULL;
                end else begin
                  word_count <= word_count + 1'b1;
                  out_data.status <= ST_OK;
                end
              end else begin
                letter_position <= (pos_eff < PW'(MAX_LEN)) ? pos_eff + 1'b1 : pos_eff;
                too_long_flag <= long_now;
              end
            end
          end
        end
        S_SCAN: begin
          rd_first <= (scan_pos == '0);
          rd_lastpos <= pos_last;
          if (pos_last) begin
            scan_pos <= '0;
            if (word_last) begin
              state <= S_WAIT;
            end else begin
              scan_word <= scan_word + 1'b1;
            end
          end else begin
            scan_pos <= scan_pos + 1'b1;
          end
        end
        S_WAIT: begin
          if (!rd_vld) begin
            out_data.found <= hit;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rd_vld) begin
        diffs <= diffs_n;
        if (rd_lastpos && diffs_n == 2'd1 && len_q == qlen) begin
          hit <= 1'b1;
        end
      end
    end
  end
endmodule

[src/omds_checker.sv]
module omds_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input omds_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_stall,
  input omds_pkg::rsp_t out_data
);
  import omds_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL
                   || out_data.status == ST_LONG)) else $error("bad status");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.status == ST_OK) else $error("found with error");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == OP_CLEAR && !out_valid |=> !out_valid)
    else $error("clear produced result");
endmodule

bind one_mismatch_dictionary_search_top omds_checker u_omds_checker (.*);

[sim/one_mismatch_dictionary_search_top_test.sv]
`timescale 1ns / 100ps

module one_mismatch_dictionary_search_top_test;
  import omds_pkg::*;

  localparam int NWORDS = MaxWordsDefault;
  localparam int NLEN = MaxLenDefault;
  localparam int RAND_ITEMS = 1500;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  always #5 clk = ~clk;

  one_mismatch_dictionary_search_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // dictionary shadow
  logic [4:0] dict_letters [NWORDS][NLEN];
  logic [5:0] dict_lengths [NWORDS];
  int unsigned dict_count;
  int unsigned word_pos;
  logic [4:0] query [NLEN];
  bit word_overflow;
  bit word_is_search;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int failures = 0;
  int idle_pct = 34;
  int sent = 0;
  longint cycles = 0;
  logic in_stall_q = 1'b1;

  function automatic bit one_letter_off(int unsigned qlen);
    int unsigned diffs;
    for (int k = 0; k < dict_count && k < NWORDS; k++) begin
      if (dict_lengths[k] != qlen) continue;
      diffs = 0;
      for (int i = 0; i < qlen && i < NLEN; i++)
        if (dict_letters[k][i] != query[i]) diffs++;
      if (diffs == 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_search(input req_t r);
    rsp_t rsp;
    bit srch;
    if (r.op == OP_CLEAR) begin
      dict_count = 0;
      word_pos = 0;
      word_overflow = 0;
      return;
    end
    if (r.op != OP_LOAD && r.op != OP_SEARCH) return;
    srch = (r.op == OP_SEARCH);
    if ((word_pos != 0 || word_overflow) && word_is_search != srch) begin
      word_pos = 0;
      word_overflow = 0;
    end
    word_is_search = srch;
    if (word_pos >= NLEN) word_overflow = 1;
    else begin
      if (srch) query[word_pos] = r.letter;
      else if (dict_count < NWORDS) dict_letters[dict_count][word_pos] = r.letter;
      word_pos++;
    end
    if (!r.last) return;
    rsp.found = 1'b0;
    if (word_overflow) rsp.status = ST_LONG;
    else if (srch) begin
      rsp.status = ST_OK;
      rsp.found = one_letter_off(word_pos);
    end else if (dict_count >= NWORDS) rsp.status = ST_FULL;
    else begin
      dict_lengths[dict_count] = word_pos[5:0];
      dict_count++;
      rsp.status = ST_OK;
    end
    word_pos = 0;
    word_overflow = 0;
    expected_rsps.insert(expected_rsps.size(), rsp);
  endtask

  task automatic push_word(input logic [1:0] op, input logic [4:0] w[$]);
    req_t r;
    for (int i = 0; i < w.size(); i++) begin
      r.op = op;
      r.letter = w[i];
      r.last = (i == w.size() - 1);
      pending_reqs.insert(pending_reqs.size(), r);
    end
  endtask

  task automatic push_one(input logic [1:0] op, input logic [4:0] l, input logic last);
    req_t r;
    r.op = op;
    r.letter = l;
    r.last = last;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic void rand_word(output logic [4:0] w[$], input int len);
    w = {};
    for (int i = 0; i < len; i++) w.insert(w.size(), 5'($urandom_range(0, 25)));
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // accepted at last rising edge; choose next
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_stall_q <= !(!rst && in_valid && !in_stall);
    if (!rst) begin
      cycles <= cycles + 1;
      if (in_valid && !in_stall) begin
        predict_search(in_data);
        sent <= sent + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result found=%0d status=%0d", out_data.found, out_data.status);
          failures++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (out_data.found !== e.found) begin
            $error("found expected %0d actual %0d", e.found, out_data.found);
            failures++;
          end
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            failures++;
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0] w[$];
    logic [4:0] v[$];
    int len;
    int kind;
    dict_count = 0;
    word_pos = 0;
    word_overflow = 0;
    word_is_search = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    push_word(OP_SEARCH, '{5'd0});
    push_word(OP_LOAD, '{5'd0, 5'd1, 5'd2});
    push_word(OP_SEARCH, '{5'd0, 5'd9, 5'd2});
    push_word(OP_SEARCH, '{5'd0, 5'd1, 5'd2});
    push_one(2'd3, 5'd31, 1'b1);
    push_word(OP_LOAD, '{5'd31, 5'd25});
    push_word(OP_SEARCH, '{5'd30, 5'd25});
    push_one(OP_LOAD, 5'd4, 1'b0);
    push_word(OP_SEARCH, '{5'd4, 5'd4});
    push_one(OP_SEARCH, 5'd1, 1'b0);
    push_one(OP_CLEAR, 5'd0, 1'b0);
    push_word(OP_SEARCH, '{5'd0, 5'd9, 5'd2});
    rand_word(w, NLEN + 2);
    push_word(OP_LOAD, w);
    rand_word(w, NLEN + 1);
    push_word(OP_SEARCH, w);
    for (int k = 0; k < NWORDS; k++) push_word(OP_LOAD, '{5'(k % 26)});
    push_word(OP_LOAD, '{5'd1});
    rand_word(w, NLEN + 1);
    push_word(OP_LOAD, w);
    push_word(OP_SEARCH, '{5'd27});
    rand_word(w, NLEN);
    push_word(OP_SEARCH, w);
    push_one(OP_CLEAR, 5'd31, 1'b1);

    // random: loads and near-match searches of mostly short words, plus clears, invalid ops and unfinished letters
    w = {};
    while (pending_reqs.size() < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, NLEN + 3) : $urandom_range(1, 4);
      if (kind < 3) push_one(OP_CLEAR, 5'($urandom), 1'($urandom));
      else if (kind < 6) push_one(2'd3, 5'($urandom), 1'($urandom));
      else if (kind < 10) push_one(2'($urandom_range(1, 2)), 5'($urandom), 1'b0);
      else if (kind < 45) begin
        rand_word(w, len);
        if ($urandom_range(0, 9) == 0) w[0] = 5'($urandom_range(26, 31));
        push_word(OP_LOAD, w);
      end else begin
        if (w.size() != 0 && $urandom_range(0, 3) != 0) begin
          v = w;
          v[$urandom_range(0, v.size() - 1)] = 5'($urandom_range(0, 25));
          if ($urandom_range(0, 4) == 0) v[$urandom_range(0, v.size() - 1)] = 5'($urandom);
        end else rand_word(v, len);
        push_word(OP_SEARCH, v);
      end
    end

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (NWORDS * NLEN + 20) @(posedge clk);
    if (failures == 0 && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // no idling during a middle stretch of the run
  always @(posedge clk) begin
    if (sent == 600) idle_pct <= 0;
    if (sent == 1000) idle_pct <= 34;
  end

endmodule

[filelist.f]
src/omds_pkg.sv
src/omds_ram.sv
src/one_mismatch_dictionary_search_top.sv
src/omds_checker.sv
sim/one_mismatch_dictionary_search_top_test.sv
